[rtl/lssi_pkg.sv]
// Shared types and constants for the log segment sparse indexer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lssi_pkg;

  // Header parse phases
  typedef enum logic [2:0] {
    PH_LEN   = 3'd0,
    PH_FLAGS = 3'd1,
    PH_COUNT = 3'd2,
    PH_FIRST = 3'd3,
    PH_SPAN  = 3'd4,
    PH_BODY  = 3'd5
  } phase_e;

  // Result kinds
  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_SEQ_ORIGIN = 1'b0,
    CFG_CKPT_STEP  = 1'b1
  } cfg_idx_e;

  localparam int unsigned SPARSE_BIT      = 6;
  localparam int unsigned VARINT_LAST_IDX = 4;
  localparam int unsigned SEQ_LAST_IDX    = 7;
  localparam logic [31:0] STEP_RESET      = 32'd4096;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    kind_e       kind;
    logic [31:0] rel_seqnum;
    logic [31:0] byte_offset;
    logic [63:0] abs_last_seqnum;
    logic        truncated;
    logic        last_result;
  } result_t;

  // Up to two result words produced by one byte; slot 1 is used only with slot 0
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

`default_nettype wire

[rtl/lssi_out_fifo.sv]
// Result queue of the log segment sparse indexer: takes up to two words per cycle.
// Depends on lssi_pkg for the result and push types.
`default_nettype none

module lssi_out_fifo
  import lssi_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire push_t   push_i,
  output logic         room_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_word_o
);

  result_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0]   count_q, count_d;
  logic                 pop;
  logic [FIFO_AW-1:0]   wr_ptr_p1;

  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a full two-word push, whatever leaves this cycle
  assign room_o      = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign wr_ptr_p1   = wr_ptr_q + FIFO_AW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.vld0) begin
      wr_ptr_d = push_i.vld1 ? wr_ptr_q + FIFO_AW'(2) : wr_ptr_p1;
    end
    rd_ptr_d = pop ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    count_d  = count_q + FIFO_CW'(push_i.vld0) + FIFO_CW'(push_i.vld1) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      mem_q[wr_ptr_p1] <= push_i.res1;
    end
  end

endmodule

`default_nettype wire

[rtl/lssi_parser.sv]
// Byte-level bundle header parser: input register, parse state and one-step update.
// Depends on lssi_pkg for phases, result types and constants.
`default_nettype none

module lssi_parser
  import lssi_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_segment_i,
  input  wire logic [63:0] seq_origin_i,
  input  wire logic [31:0] checkpoint_step_i,
  input  wire logic        room_i,
  output push_t            push_o
);

  // Input register
  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic        eos_q;
  logic        fire;

  // Parse state
  phase_e                 phase_q, phase_d;
  logic [31:0]            acc_q, acc_d;
  logic [2:0]             shift_q, shift_d;
  logic                   sparse_q, sparse_d;
  logic [31:0]            len_q, len_d;
  logic [31:0]            left_q, left_d;
  logic [31:0]            msg_q, msg_d;
  logic [31:0]            first_q, first_d;
  logic [31:0]            next_q, next_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] ckpt_q, ckpt_d;
  logic                   bogus_q, bogus_d;

  // Step helpers
  logic [OFFSET_BITS-1:0] p_after;
  logic [31:0]            vt_acc;
  logic                   vt_done;
  logic [4:0]             vt_shamt;
  logic                   ck;
  logic [31:0]            ck_raw;
  logic                   fin;
  logic [31:0]            fin_first;
  logic [31:0]            fin_next;
  logic [31:0]            fr;
  logic [31:0]            last_rel;
  logic                   trunc;
  logic                   entry;
  result_t                ent_res;
  result_t                sum_res;

  assign fire       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_segment_i;
    end
  end

  assign p_after  = off_q + OFFSET_BITS'(1);
  assign vt_shamt = 5'(shift_q) * 5'd7;
  assign vt_acc   = acc_q | ({25'd0, byte_q[6:0]} << vt_shamt);
  assign vt_done  = !byte_q[7] || (shift_q >= 3'(VARINT_LAST_IDX));

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    shift_d   = shift_q;
    sparse_d  = sparse_q;
    len_d     = len_q;
    left_d    = left_q;
    msg_d     = msg_q;
    first_d   = first_q;
    next_d    = next_q;
    off_d     = p_after;
    start_d   = start_q;
    ckpt_d    = ckpt_q;
    bogus_d   = bogus_q;
    ck        = 1'b0;
    ck_raw    = '0;
    fin       = 1'b0;
    fin_first = '0;
    fin_next  = '0;
    fr        = first_q;
    entry     = 1'b0;
    last_rel  = '0;
    trunc     = 1'b0;

    if (phase_q != PH_LEN && left_q != '0) begin
      left_d = left_q - 32'd1;
    end

    case (phase_q)
      PH_LEN: begin
        if (shift_q == '0 && acc_q == '0) begin
          start_d = off_q;
        end
        if (vt_done) begin
          len_d   = vt_acc;
          left_d  = vt_acc;
          acc_d   = '0;
          shift_d = '0;
          phase_d = PH_FLAGS;
        end else begin
          acc_d   = vt_acc;
          shift_d = shift_q + 3'd1;
        end
      end
      PH_FLAGS: begin
        sparse_d = byte_q[SPARSE_BIT];
        acc_d    = '0;
        shift_d  = '0;
        if (byte_q[5:2] != 4'd0) begin
          ck     = 1'b1;
          ck_raw = {28'd0, byte_q[5:2]};
        end else begin
          phase_d = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (vt_done) begin
          ck     = 1'b1;
          ck_raw = vt_acc;
        end else begin
          acc_d   = vt_acc;
          shift_d = shift_q + 3'd1;
        end
      end
      PH_FIRST: begin
        // Only the low four bytes survive the 32-bit relative value
        if (!shift_q[2]) begin
          fr = first_q | ({24'd0, byte_q} << {shift_q[1:0], 3'b000});
        end
        if (shift_q == 3'(SEQ_LAST_IDX)) begin
          shift_d = '0;
          acc_d   = '0;
          first_d = fr - seq_origin_i[31:0];
          if (msg_q != 32'd1) begin
            phase_d = PH_SPAN;
          end else begin
            fin       = 1'b1;
            fin_first = first_d;
            fin_next  = first_d + 32'd1;
          end
        end else begin
          first_d = fr;
          shift_d = shift_q + 3'd1;
        end
      end
      PH_SPAN: begin
        if (vt_done) begin
          shift_d   = '0;
          acc_d     = '0;
          fin       = 1'b1;
          fin_first = first_q;
          fin_next  = first_q + vt_acc + 32'd2;
        end else begin
          acc_d   = vt_acc;
          shift_d = shift_q + 3'd1;
        end
      end
      default: begin
        if (left_d == '0) begin
          phase_d = PH_LEN;
        end
      end
    endcase

    // Count known: clamp bogus counts, then go on to the sparse fields or finish
    if (ck) begin
      bogus_d = (ck_raw > len_q);
      msg_d   = bogus_d ? 32'd1 : ck_raw;
      acc_d   = '0;
      shift_d = '0;
      if (sparse_d) begin
        first_d = '0;
        phase_d = PH_FIRST;
      end else begin
        fin       = 1'b1;
        fin_first = next_q;
        fin_next  = next_q + msg_d;
      end
    end

    // Header done
    if (fin) begin
      next_d = fin_next;
      if (p_after >= ckpt_q || bogus_d) begin
        entry = 1'b1;
        if (bogus_d) begin
          ckpt_d = OFFSET_BITS'(32'(p_after) + left_d);
        end else begin
          ckpt_d = OFFSET_BITS'(32'(start_q) + checkpoint_step_i);
        end
      end
      phase_d = (left_d != '0) ? PH_BODY : PH_LEN;
    end

    if (eos_q) begin
      last_rel = (next_d != '0) ? next_d - 32'd1 : '0;
      trunc    = (phase_d != PH_LEN) || (shift_d != '0) || (acc_d != '0);
      // Start a fresh segment at offset zero
      phase_d  = PH_LEN;
      acc_d    = '0;
      shift_d  = '0;
      sparse_d = 1'b0;
      len_d    = '0;
      left_d   = '0;
      msg_d    = '0;
      first_d  = '0;
      next_d   = '0;
      off_d    = '0;
      start_d  = '0;
      ckpt_d   = '0;
      bogus_d  = 1'b0;
    end
  end

  always_comb begin
    ent_res.kind            = KIND_ENTRY;
    ent_res.rel_seqnum      = fin_first;
    ent_res.byte_offset     = 32'(start_q);
    ent_res.abs_last_seqnum = '0;
    ent_res.truncated       = 1'b0;
    ent_res.last_result     = !eos_q;

    sum_res.kind            = KIND_SUMMARY;
    sum_res.rel_seqnum      = last_rel;
    sum_res.byte_offset     = '0;
    sum_res.abs_last_seqnum = seq_origin_i + 64'(last_rel);
    sum_res.truncated       = trunc;
    sum_res.last_result     = 1'b1;

    push_o.vld0 = fire && (entry || eos_q);
    push_o.vld1 = fire && entry && eos_q;
    push_o.res0 = entry ? ent_res : sum_res;
    push_o.res1 = sum_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      acc_q    <= '0;
      shift_q  <= '0;
      sparse_q <= 1'b0;
      len_q    <= '0;
      left_q   <= '0;
      msg_q    <= '0;
      first_q  <= '0;
      next_q   <= '0;
      off_q    <= '0;
      start_q  <= '0;
      ckpt_q   <= '0;
      bogus_q  <= 1'b0;
    end else if (fire) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      sparse_q <= sparse_d;
      len_q    <= len_d;
      left_q   <= left_d;
      msg_q    <= msg_d;
      first_q  <= first_d;
      next_q   <= next_d;
      off_q    <= off_d;
      start_q  <= start_d;
      ckpt_q   <= ckpt_d;
      bogus_q  <= bogus_d;
    end
  end

endmodule

`default_nettype wire

[rtl/log_segment_sparse_indexer_core.sv]
// Top level of the log segment sparse indexer: config registers, parser and result queue.
// Depends on lssi_pkg, lssi_parser and lssi_out_fifo.
`default_nettype none

// The block reads a log segment one byte per word on the input channel, with
// end_of_segment_i high on the final byte. It walks each bundle header (varint
// length, flag byte, message count from the flags or a varint, and for sparse
// bundles a 64-bit first sequence number and, for counts other than 1, a varint span) and tracks the next
// relative sequence number. Whenever a header completes at or past the current
// checkpoint an index entry (result_kind 0: relative first sequence number and
// bundle start offset) is queued, and the checkpoint moves to bundle start plus
// checkpoint_step. A message count larger than its bundle length is taken as 1,
// always indexed, and pushes the checkpoint to that bundle's end. The final
// byte adds a summary (result_kind 1) with the last relative and absolute
// sequence numbers and a truncation flag, after which parsing restarts at
// offset 0. last_result_o marks the final word caused by each byte. Rate: one
// byte per cycle; each byte passes through an input register and the header
// logic into a four-word result queue, and the parser takes a byte only
// while the queue has room for two words, so back-pressure on the output
// stalls input once three or more words wait in the queue. The result words
// of an accepted byte are written into the queue as the byte leaves the input
// register. Write the sequence origin (index 0) and checkpoint_step (index 1)
// only while the block is idle; cfg_ready_o is always high. Byte offsets are
// kept modulo 2^OFFSET_BITS.
module log_segment_sparse_indexer_core
  import lssi_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // Byte input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_segment_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [31:0]      rel_seqnum_o,
  output logic [31:0]      byte_offset_o,
  output logic [63:0]      abs_last_seqnum_o,
  output logic             truncated_o,
  output logic             last_result_o
);

  logic [63:0] seq_origin_q;
  logic [31:0] ckpt_step_q;
  push_t       push;
  logic        room;
  result_t     out_word;

  // Configuration registers: always ready, written on the handshake
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_origin_q <= '0;
      ckpt_step_q  <= STEP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SEQ_ORIGIN: seq_origin_q <= cfg_data_i;
        CFG_CKPT_STEP:  ckpt_step_q  <= cfg_data_i[31:0];
        default:        seq_origin_q <= seq_origin_q;
      endcase
    end
  end

  // Header parser: one byte per cycle while the queue has room, up to two result words per byte
  lssi_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .end_of_segment_i  (end_of_segment_i),
    .seq_origin_i      (seq_origin_q),
    .checkpoint_step_i (ckpt_step_q),
    .room_i            (room),
    .push_o            (push)
  );

  // Result queue decouples the output handshake from parsing
  lssi_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word)
  );

  assign result_kind_o     = out_word.kind;
  assign rel_seqnum_o      = out_word.rel_seqnum;
  assign byte_offset_o     = out_word.byte_offset;
  assign abs_last_seqnum_o = out_word.abs_last_seqnum;
  assign truncated_o       = out_word.truncated;
  assign last_result_o     = out_word.last_result;

endmodule

`default_nettype wire

[test/lssi_index_checker.sv]
`timescale 1ns / 100ps
// Result checker for the log segment sparse indexer: predicts index entries and
// segment summaries from the accepted bytes and compares them with the result channel.
// Depends on lssi_pkg for the result word layout, kinds, phases and register indexes.

module lssi_index_checker
  import lssi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_segment_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        result_kind_i,
  input  logic [31:0] rel_seqnum_i,
  input  logic [31:0] byte_offset_i,
  input  logic [63:0] abs_last_seqnum_i,
  input  logic        truncated_i,
  input  logic        last_result_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          entries_o,
  output int          summaries_o
);

  localparam int REPORT_LIMIT = 200;

  // Register copies
  logic [63:0] base_seq;
  logic [31:0] ckpt_step;

  // Parser copy
  phase_e      phase;
  logic [31:0] vacc;
  logic [2:0]  vshift;
  logic [7:0]  hdr_flags;
  logic [31:0] bndl_length;
  logic [31:0] bytes_left;
  logic [31:0] msg_count;
  logic [63:0] first_seq;
  logic [31:0] next_rel;
  logic [31:0] cur_off;
  logic [31:0] bundle_start;
  logic [31:0] ckpt_at;
  logic        bogus;

  result_t expected_words[$];
  result_t byte_results[2];
  int      byte_result_cnt;
  result_t seen_word;

  int mismatches;
  int pending_q;
  int entries_seen;
  int summaries_seen;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_q;
  assign entries_o    = entries_seen;
  assign summaries_o  = summaries_seen;

  task automatic clear_parse();
    phase        = PH_LEN;
    vacc         = '0;
    vshift       = '0;
    hdr_flags    = '0;
    bndl_length  = '0;
    bytes_left   = '0;
    msg_count    = '0;
    first_seq    = '0;
    next_rel     = '0;
    cur_off      = '0;
    bundle_start = '0;
    ckpt_at      = '0;
    bogus        = 1'b0;
  endtask

  // Low group first; the fifth byte ends the varint whatever its top bit says
  function automatic logic take_varint_byte(input logic [7:0] b);
    vacc = vacc | (32'(b[6:0]) << (7 * vshift));
    if (!b[7] || vshift >= 3'd4) begin
      vshift = '0;
      return 1'b1;
    end
    vshift = vshift + 3'd1;
    return 1'b0;
  endfunction

  task automatic add_word(input kind_e kind, input logic [31:0] rel, input logic [31:0] off,
                          input logic [63:0] abs_last, input logic trunc);
    result_t w;
    w.kind            = kind;
    w.rel_seqnum      = rel;
    w.byte_offset     = off;
    w.abs_last_seqnum = abs_last;
    w.truncated       = trunc;
    w.last_result     = 1'b0;
    byte_results[byte_result_cnt] = w;
    byte_result_cnt++;
  endtask

  task automatic close_header(input logic [31:0] first_rel, input logic [31:0] new_next,
                              input logic [31:0] p_after);
    next_rel = new_next;
    if (p_after >= ckpt_at || bogus) begin
      add_word(KIND_ENTRY, first_rel, bundle_start, '0, 1'b0);
      // A bogus count pushes the checkpoint to the end of its bundle
      ckpt_at = bogus ? p_after + bytes_left : bundle_start + ckpt_step;
    end
    phase = (bytes_left != 0) ? PH_BODY : PH_LEN;
  endtask

  task automatic count_known(input logic [31:0] raw, input logic [31:0] p_after);
    bogus     = raw > bndl_length;
    msg_count = bogus ? 32'd1 : raw;
    vacc      = '0;
    vshift    = '0;
    if (hdr_flags[SPARSE_BIT]) begin
      first_seq = '0;
      phase     = PH_FIRST;
    end else begin
      close_header(next_rel, next_rel + msg_count, p_after);
    end
  endtask

  task automatic parse_segment_byte(input logic [7:0] b, input logic eos);
    logic [31:0] here;
    logic [31:0] p_after;
    logic [31:0] f;
    logic [31:0] last_rel;
    logic        trunc;
    here            = cur_off;
    p_after         = here + 32'd1;
    byte_result_cnt = 0;
    if (phase != PH_LEN && bytes_left != 0) bytes_left = bytes_left - 32'd1;

    case (phase)
      PH_LEN: begin
        if (vshift == 0 && vacc == 0) bundle_start = here;
        if (take_varint_byte(b)) begin
          bndl_length = vacc;
          bytes_left  = vacc;
          vacc        = '0;
          phase       = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        hdr_flags = b;
        vacc      = '0;
        vshift    = '0;
        if (b[5:2] != 4'd0) count_known(32'(b[5:2]), p_after);
        else phase = PH_COUNT;
      end
      PH_COUNT: begin
        if (take_varint_byte(b)) count_known(vacc, p_after);
      end
      PH_FIRST: begin
        first_seq = first_seq | (64'(b) << (8 * vshift));
        if (vshift >= 3'd7) begin
          vshift    = '0;
          vacc      = '0;
          first_seq = {32'd0, 32'(first_seq - base_seq)};
          if (msg_count != 32'd1) begin
            phase = PH_SPAN;
          end else begin
            f = first_seq[31:0];
            close_header(f, f + 32'd1, p_after);
          end
        end else begin
          vshift = vshift + 3'd1;
        end
      end
      PH_SPAN: begin
        if (take_varint_byte(b)) begin
          f        = first_seq[31:0];
          last_rel = f + vacc + 32'd1;
          vacc     = '0;
          close_header(f, last_rel + 32'd1, p_after);
        end
      end
      default: begin
        if (bytes_left == 0) phase = PH_LEN;
      end
    endcase

    cur_off = p_after;

    if (eos) begin
      last_rel = (next_rel != 0) ? next_rel - 32'd1 : 32'd0;
      trunc    = (phase != PH_LEN) || (vshift != 0) || (vacc != 0);
      add_word(KIND_SUMMARY, last_rel, '0, base_seq + 64'(last_rel), trunc);
      clear_parse();
    end

    for (int i = 0; i < byte_result_cnt; i++) begin
      if (i == byte_result_cnt - 1) byte_results[i].last_result = 1'b1;
      expected_words.push_back(byte_results[i]);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_word(input result_t seen);
    result_t want;
    if (expected_words.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: result word with nothing expected: expected none, actual kind %0d rel 0x%0h",
                 $time, seen.kind, seen.rel_seqnum);
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      compare_field("result_kind", 64'(want.kind), 64'(seen.kind));
      compare_field("rel_seqnum", 64'(want.rel_seqnum), 64'(seen.rel_seqnum));
      compare_field("byte_offset", 64'(want.byte_offset), 64'(seen.byte_offset));
      compare_field("abs_last_seqnum", want.abs_last_seqnum, seen.abs_last_seqnum);
      compare_field("truncated", 64'(want.truncated), 64'(seen.truncated));
      compare_field("last_result", 64'(want.last_result), 64'(seen.last_result));
      if (want.kind == KIND_ENTRY) entries_seen++;
      else summaries_seen++;
    end
  endtask

  initial begin
    mismatches     = 0;
    entries_seen   = 0;
    summaries_seen = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_seq  = '0;
      ckpt_step = STEP_RESET;
      clear_parse();
      expected_words.delete();
      pending_q <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_word.kind            = kind_e'(result_kind_i);
        seen_word.rel_seqnum      = rel_seqnum_i;
        seen_word.byte_offset     = byte_offset_i;
        seen_word.abs_last_seqnum = abs_last_seqnum_i;
        seen_word.truncated       = truncated_i;
        seen_word.last_result     = last_result_i;
        check_word(seen_word);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_SEQ_ORIGIN) base_seq = cfg_data_i;
        else ckpt_step = cfg_data_i[31:0];
      end
      if (in_valid_i && in_ready_i) parse_segment_byte(data_byte_i, end_of_segment_i);
      pending_q <= expected_words.size();
    end
  end

endmodule

[test/log_segment_sparse_indexer_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top for log_segment_sparse_indexer_core: clock, reset, byte and register
// stimulus, output stalls and the verdict. Depends on lssi_pkg and lssi_index_checker.

module log_segment_sparse_indexer_core_tb;
  import lssi_pkg::*;

  localparam int RANDOM_BYTES  = 1900;
  localparam int PHASES        = 10;
  localparam int SETTLE_CYCLES = 8;      // margin after the last expected word
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk_i;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  cfg_idx_e    cfg_index_i      = CFG_SEQ_ORIGIN;
  logic [63:0] cfg_data_i       = '0;
  logic        in_valid_i       = 1'b0;
  logic [7:0]  data_byte_i      = '0;
  logic        end_of_segment_i = 1'b0;
  logic        out_ready_i      = 1'b0;

  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        result_kind_o;
  logic [31:0] rel_seqnum_o;
  logic [31:0] byte_offset_o;
  logic [63:0] abs_last_seqnum_o;
  logic        truncated_o;
  logic        last_result_o;

  int fail_count;
  int words_pending;
  int entries_checked;
  int summaries_checked;

  // Stimulus bookkeeping
  logic [7:0]  segment_bytes[$];
  int          bytes_sent    = 0;
  int          segments_sent = 0;
  int          cycles        = 0;
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  logic [63:0] cur_base      = '0;
  logic [31:0] cur_step      = STEP_RESET;

  log_segment_sparse_indexer_core #(
    .OFFSET_BITS(32)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_segment_i (end_of_segment_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .rel_seqnum_o     (rel_seqnum_o),
    .byte_offset_o    (byte_offset_o),
    .abs_last_seqnum_o(abs_last_seqnum_o),
    .truncated_o      (truncated_o),
    .last_result_o    (last_result_o)
  );

  // The checker watches all three channels and keeps its own copy of the parser
  lssi_index_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_segment_i (end_of_segment_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_i    (result_kind_o),
    .rel_seqnum_i     (rel_seqnum_o),
    .byte_offset_i    (byte_offset_o),
    .abs_last_seqnum_i(abs_last_seqnum_o),
    .truncated_i      (truncated_o),
    .last_result_i    (last_result_o),
    .fail_count_o     (fail_count),
    .pending_o        (words_pending),
    .entries_o        (entries_checked),
    .summaries_o      (summaries_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result channel at the rate of the current phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog: a hung handshake or a missing result word ends up here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result words still outstanding",
               cycles, words_pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte word, with random idle cycles ahead of it, and hold it until taken.
  // Valid stays high on return; the caller drops it before going quiet.
  task automatic send_byte(input logic [7:0] value, input logic last_of_segment);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= value;
    end_of_segment_i <= last_of_segment;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Hold a register write word until it is taken; the caller drops valid after the last one
  task automatic write_register(input cfg_idx_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Drop input valid, wait for every expected word to come out, then let the
  // pipeline settle, since trailing bytes may still be in flight without a result
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int varint_size(input logic [31:0] value, input int pad);
    int n;
    n = 1;
    while (n < 5 && (value >> (7 * n)) != 0) n++;
    return (n + pad > 5) ? 5 : n + pad;
  endfunction

  // Append a varint, optionally padded with zero groups up to five bytes
  task automatic push_varint(input logic [31:0] value, input int pad);
    int total;
    total = varint_size(value, pad);
    for (int i = 0; i < total; i++)
      segment_bytes.push_back({(i < total - 1), 7'(value >> (7 * i))});
  endtask

  // Append one bundle with random shape: plain or sparse, count in the flags or as a
  // varint, sometimes a count larger than the bundle, sometimes a header longer than it
  task automatic add_bundle();
    logic        sparse;
    logic        count_in_flags;
    logic        with_span;
    logic [31:0] count;
    logic [31:0] span;
    logic [31:0] len;
    logic [63:0] first;
    logic [7:0]  flags;
    int          hdr;
    int          body;
    int          count_pad;
    int          span_pad;
    int          len_pad;
    int          len_end;
    int          emitted;
    sparse = ($urandom_range(1) == 0);
    case ($urandom_range(9))
      0:       count = $urandom();
      1, 2:    count = $urandom_range(300, 16);
      default: count = $urandom_range(15, 0);
    endcase
    count_in_flags = (count >= 1 && count <= 15) && ($urandom_range(3) != 0);
    count_pad = ($urandom_range(7) == 0) ? $urandom_range(4, 1) : 0;
    span_pad  = ($urandom_range(7) == 0) ? $urandom_range(4, 1) : 0;
    len_pad   = ($urandom_range(9) == 0) ? $urandom_range(4, 1) : 0;
    span = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(200, 0);
    body = ($urandom_range(19) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 0);
    hdr  = 1 + (count_in_flags ? 0 : varint_size(count, count_pad)) + (sparse ? 8 : 0);

    if ($urandom_range(11) == 0) begin
      // header overrun: the length does not even cover the header
      len = $urandom_range(hdr - 1, 0);
    end else begin
      len = hdr + body;
      if (sparse && count != 1 && count <= len) len = len + varint_size(span, span_pad);
    end
    // a bogus count is taken as one message, so no span follows it
    with_span = sparse && count != 1 && count <= len;

    first = ($urandom_range(3) == 0) ? {$urandom(), $urandom()}
                                     : cur_base + 64'($urandom_range(5000, 0));
    flags = {1'($urandom_range(1)), sparse, count_in_flags ? count[3:0] : 4'd0,
             2'($urandom_range(3))};

    push_varint(len, len_pad);
    len_end = segment_bytes.size();
    segment_bytes.push_back(flags);
    if (!count_in_flags) push_varint(count, count_pad);
    if (sparse)
      for (int i = 0; i < 8; i++) segment_bytes.push_back(first[8 * i +: 8]);
    if (with_span) push_varint(span, span_pad);
    emitted = segment_bytes.size() - len_end;
    for (int i = emitted; i < int'(len); i++) segment_bytes.push_back(8'($urandom()));
  endtask

  // Build one segment: mostly well-formed bundles, some cut short, some pure noise
  task automatic build_segment();
    int cut;
    segment_bytes.delete();
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(40, 1)) segment_bytes.push_back(8'($urandom()));
    end else begin
      repeat ($urandom_range(6, 1)) add_bundle();
      if ($urandom_range(5) == 0 && segment_bytes.size() > 1) begin
        cut = $urandom_range(segment_bytes.size() - 1, 1);
        while (segment_bytes.size() > cut) void'(segment_bytes.pop_back());
      end
    end
  endtask

  task automatic send_segment();
    for (int i = 0; i < segment_bytes.size(); i++)
      send_byte(segment_bytes[i], i == segment_bytes.size() - 1);
    segments_sent++;
  endtask

  initial begin
    int budget;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed segment under reset settings: count in the flags, a bogus varint
    // count that forces an entry, a sparse bundle whose first number wraps the
    // relative count, then a five-byte length whose last byte still has its top
    // bit set and a bundle cut short by the end of the segment
    segment_bytes = '{8'h02, 8'h04, 8'hFF,
                      8'h03, 8'h00, 8'h85, 8'h00,
                      8'h09, 8'h44, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h3C};
    send_segment();
    wait_until_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      // Pick register values; the extremes come first, zero step indexes every bundle
      case (phase)
        0: begin cur_base = '0;                     cur_step = 32'd1;          end
        1: begin cur_base = '1;                     cur_step = 32'hFFFF_FFFF;  end
        2: begin cur_base = {$urandom(), $urandom()}; cur_step = 32'd0;        end
        3: begin cur_base = {$urandom(), $urandom()}; cur_step = $urandom_range(40, 2); end
        4: begin cur_base = '0;                     cur_step = STEP_RESET;     end
        default: begin
          cur_base = {$urandom(), $urandom()};
          cur_step = $urandom_range(100, 1);
        end
      endcase
      write_register(CFG_SEQ_ORIGIN, cur_base);
      write_register(CFG_CKPT_STEP, {32'd0, cur_step});
      cfg_valid_i <= 1'b0;

      // Rotate idling: none, sender idle, receiver stalls, both lightly
      case (phase % 4)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 55; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 55; end
        default: begin in_idle_pct = 7;  out_stall_pct = 7;  end
      endcase

      budget = bytes_sent + RANDOM_BYTES / PHASES;
      while (bytes_sent < budget) begin
        build_segment();
        send_segment();
      end
      wait_until_drained();
    end

    $display("Ran %0d bytes in %0d segments over %0d register settings and four idle mixes.",
             bytes_sent, segments_sent, PHASES + 1);
    $display("Checked %0d index entries and %0d segment summaries; %0d mismatches.",
             entries_checked, summaries_checked, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
